// ----- rtl/rzn_pkg.sv -----
// package for the relay autotuner: phase codes, controller states,
// command and status structs, register indexes and fixed-point constants
// no dependencies
`default_nettype none

package rzn_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_OSC  = 2'd1,
        PH_DONE = 2'd2,
        PH_ERR  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROC,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic process;
        logic mul;
        logic div_start;
        logic kp_write;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_valid;
        logic need_div;
        logic div_done;
        logic out_free;
    } ctrl_stat_t;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] CFG_SETPOINT  = 2'd0;
    localparam logic [1:0] CFG_RELAY_AMP = 2'd1;
    localparam logic [1:0] CFG_MIN_HALF  = 2'd2;
    localparam logic [1:0] CFG_CROSSINGS = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int AMP_W      = 11;
    localparam int MINH_W     = 15;
    localparam int CNT_W      = 4;
    localparam int DRIVE_W    = 12;
    localparam int GAIN_W     = 32;

    localparam logic [AMP_W-1:0]  DRIVE_MAX      = 11'd1024;
    localparam logic [AMP_W-1:0]  AMP_RESET      = 11'd512;
    localparam logic [MINH_W-1:0] MINH_RESET     = 15'd6;
    localparam logic [CNT_W-1:0]  CROSSING_RESET = 4'd6;

    // round(2.4 * 256 * 65536 / pi)
    localparam int KP_SCALE_W = 24;
    localparam logic [KP_SCALE_W-1:0] KP_SCALE = 24'd12816849;
    localparam int PROD_W = AMP_W + KP_SCALE_W;

endpackage

`default_nettype wire

// ----- rtl/rzn_if.sv -----
// valid/ready channel interfaces for the relay autotuner:
// input items, result items and configuration writes
// no dependencies
`default_nettype none

interface rzn_in_if #(
    parameter int TEMP_WIDTH = 16,
    parameter int TIME_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [TEMP_WIDTH-1:0] temperature;
    logic [TIME_WIDTH-1:0]        time_ms;

    modport source (output valid, cmd, temperature, time_ms, input ready);
    modport sink   (input valid, cmd, temperature, time_ms, output ready);
endinterface

interface rzn_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] heater_drive;
    logic [1:0]         status;
    logic [31:0]        gain_kp;
    logic [31:0]        integral_time_ms;
    logic [31:0]        derivative_time_ms;

    modport source (output valid, heater_drive, status, gain_kp, integral_time_ms,
                    derivative_time_ms, input ready);
    modport sink   (input valid, heater_drive, status, gain_kp, integral_time_ms,
                    derivative_time_ms, output ready);
endinterface

interface rzn_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/relay_autotuner_ziegler_nichols_core.sv -----
// top level of the relay-feedback autotuner with Ziegler-Nichols gains
// depends on rzn_pkg, rzn_if, rzn_ctrl, rzn_datapath
//
// channel  dir  handshake     payload
// item     in   valid/ready   cmd, temperature, time_ms
// result   out  valid/ready   heater_drive, status, gain_kp, integral/derivative time
// cfg      in   valid/ready   index, data (always ready)
//
// a word passes capture, update and the result register
// the word that ends a good run also passes the kp product, the divider load and the
// bit-serial kp divider (one quotient bit per cycle over 36 bits)
// a full result register holds the controller before it returns to idle
// rst_n clears the tuning state at once, no clearing pass
`default_nettype none

module relay_autotuner_ziegler_nichols_core #(
    parameter int TEMP_WIDTH = 16,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rzn_in_if.sink     item,
    rzn_out_if.source  result,
    rzn_cfg_if.sink    cfg
);
    import rzn_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    rzn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    rzn_datapath #(
        .TEMP_WIDTH (TEMP_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

`default_nettype wire

// ----- rtl/rzn_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module rzn_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numerator,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(NUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W:0]    rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numerator;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/rzn_ctrl.sv -----
// controller state machine for the relay autotuner
// depends on rzn_pkg
`default_nettype none

module rzn_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rzn_pkg::ctrl_stat_t stat,
    output rzn_pkg::ctrl_cmd_t      cmd
);
    import rzn_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (stat.item_valid)
                    state_next = S_PROC;
            S_PROC:
                state_next = stat.need_div ? S_MUL : S_EMIT;
            S_MUL:
                state_next = S_LOAD;
            S_LOAD:
                state_next = S_DIV;
            S_DIV:
                if (stat.div_done)
                    state_next = S_EMIT;
            S_EMIT:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: cmd.take      = 1'b1;
            S_PROC: cmd.process   = 1'b1;
            S_MUL:  cmd.mul       = 1'b1;
            S_LOAD: cmd.div_start = 1'b1;
            S_DIV:  cmd.kp_write  = stat.div_done;
            S_EMIT: cmd.emit      = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/rzn_datapath.sv -----
// datapath for the relay autotuner: config registers, tuning state,
// relay decision, swing and timing, kp product and divider, result word
// depends on rzn_pkg, rzn_if, rzn_div
`default_nettype none

module rzn_datapath #(
    parameter int TEMP_WIDTH = 16,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    rzn_in_if.sink                   item,
    rzn_out_if.source                result,
    rzn_cfg_if.sink                  cfg,
    input  wire rzn_pkg::ctrl_cmd_t  cmd,
    output rzn_pkg::ctrl_stat_t      stat
);
    import rzn_pkg::*;

    localparam int NUM_W   = (PROD_W > TEMP_WIDTH ? PROD_W : TEMP_WIDTH) + 1;
    localparam int CMP_W   = (TEMP_WIDTH > MINH_W + 1 ? TEMP_WIDTH : MINH_W + 1) + 1;
    localparam int DELTA_W = (TIME_WIDTH < 34) ? 34 : TIME_WIDTH;

    localparam logic signed [TEMP_WIDTH-1:0] TEMP_MIN = {1'b1, {(TEMP_WIDTH-1){1'b0}}};
    localparam logic signed [TEMP_WIDTH-1:0] TEMP_MAX = {1'b0, {(TEMP_WIDTH-1){1'b1}}};

    // configuration
    logic signed [TEMP_WIDTH-1:0] setpoint_reg;
    logic [AMP_W-1:0]             amp_reg;
    logic [MINH_W-1:0]            minh_reg;
    logic [CNT_W-1:0]             needed_reg;
    logic [TEMP_WIDTH-1:0]        sp_cfg;

    // captured word
    logic                         cmd_reg;
    logic signed [TEMP_WIDTH-1:0] temp_reg;
    logic [TIME_WIDTH-1:0]        time_reg;

    // tuning state
    phase_t                       phase_reg;
    logic                         was_below_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [TIME_WIDTH-1:0]        last_time_reg;
    logic signed [TEMP_WIDTH-1:0] peak_reg;
    logic signed [TEMP_WIDTH-1:0] valley_reg;
    logic [GAIN_W-1:0]            kp_reg;
    logic [GAIN_W-1:0]            ti_reg;
    logic [GAIN_W-1:0]            td_reg;

    // working values
    logic [TEMP_WIDTH-1:0]        diff_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [DRIVE_W-1:0]           drive_reg;

    // result word
    logic                         out_valid_reg;
    logic [DRIVE_W-1:0]           out_drive_reg;
    logic [1:0]                   out_status_reg;
    logic [GAIN_W-1:0]            out_kp_reg;
    logic [GAIN_W-1:0]            out_ti_reg;
    logic [GAIN_W-1:0]            out_td_reg;

    logic                         is_sample;
    logic                         osc;
    logic                         below;
    logic                         crossing;
    logic                         reach;
    logic                         finish;
    logic                         low_swing;
    logic [AMP_W-1:0]             amp_clamp;
    logic [DRIVE_W-1:0]           drive_pos;
    logic [DRIVE_W-1:0]           drive_next;
    logic signed [TEMP_WIDTH-1:0] peak_next;
    logic signed [TEMP_WIDTH-1:0] valley_next;
    logic [TEMP_WIDTH:0]          diff_wide;
    logic [TEMP_WIDTH-1:0]        diff_next;
    logic [CNT_W-1:0]             count_next;
    logic [TIME_WIDTH-1:0]        delta;
    logic [DELTA_W-1:0]           delta_ext;
    logic [NUM_W-1:0]             numerator;
    logic [NUM_W-1:0]             quotient;
    logic                         div_done;
    logic                         out_free;
    logic                         capture;

    generate
        if (TEMP_WIDTH <= CFG_DATA_W)
        begin : g_sp_narrow
            assign sp_cfg = cfg.data[TEMP_WIDTH-1:0];
        end
        else
        begin : g_sp_wide
            assign sp_cfg = {{(TEMP_WIDTH-CFG_DATA_W){1'b0}}, cfg.data};
        end
    endgenerate

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            amp_reg      <= AMP_RESET;
            minh_reg     <= MINH_RESET;
            needed_reg   <= CROSSING_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SETPOINT:  setpoint_reg <= sp_cfg;
                CFG_RELAY_AMP: amp_reg      <= cfg.data[AMP_W-1:0];
                CFG_MIN_HALF:  minh_reg     <= cfg.data[MINH_W-1:0];
                CFG_CROSSINGS: needed_reg   <= cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture
    assign item.ready = cmd.take;
    assign capture    = cmd.take && item.valid;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            cmd_reg  <= item.cmd;
            temp_reg <= item.temperature;
            time_reg <= item.time_ms;
        end
    end

    // relay and crossing logic
    assign is_sample  = cmd_reg == CMD_SAMPLE;
    assign osc        = phase_reg == PH_OSC;
    assign below      = temp_reg < setpoint_reg;
    assign amp_clamp  = (amp_reg > DRIVE_MAX) ? DRIVE_MAX : amp_reg;
    assign drive_pos  = {1'b0, amp_clamp};
    assign peak_next  = (temp_reg > peak_reg) ? temp_reg : peak_reg;
    assign valley_next = (temp_reg < valley_reg) ? temp_reg : valley_reg;
    assign diff_wide  = {peak_next[TEMP_WIDTH-1], peak_next}
                      - {valley_next[TEMP_WIDTH-1], valley_next};
    assign diff_next  = diff_wide[TEMP_WIDTH] ? '0 : diff_wide[TEMP_WIDTH-1:0];
    assign low_swing  = CMP_W'(diff_next) < CMP_W'({minh_reg, 1'b0});
    assign crossing   = below != was_below_reg;
    assign count_next = count_reg + 1'b1;
    assign reach      = count_next >= needed_reg;
    assign finish     = is_sample && osc && crossing && reach;
    assign delta      = time_reg - last_time_reg;
    assign delta_ext  = DELTA_W'(delta);

    always_comb
    begin
        if (!is_sample || !osc || finish)
            drive_next = '0;
        else if (below)
            drive_next = drive_pos;
        else
            drive_next = DRIVE_W'(0) - drive_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            was_below_reg <= 1'b1;
            count_reg     <= '0;
            last_time_reg <= '0;
            peak_reg      <= TEMP_MIN;
            valley_reg    <= TEMP_MAX;
            kp_reg        <= '0;
            ti_reg        <= '0;
            td_reg        <= '0;
        end
        else
        begin
            if (cmd.process)
            begin
                if (!is_sample)
                begin
                    phase_reg     <= PH_OSC;
                    count_reg     <= '0;
                    peak_reg      <= TEMP_MIN;
                    valley_reg    <= TEMP_MAX;
                    last_time_reg <= time_reg;
                end
                else if (osc)
                begin
                    peak_reg   <= peak_next;
                    valley_reg <= valley_next;
                    if (crossing)
                    begin
                        last_time_reg <= time_reg;
                        count_reg     <= count_next;
                        was_below_reg <= below;
                    end
                    if (finish)
                    begin
                        if (low_swing)
                            phase_reg <= PH_ERR;
                        else
                        begin
                            phase_reg <= PH_DONE;
                            ti_reg    <= delta_ext[31:0];
                            td_reg    <= delta_ext[33:2];
                        end
                    end
                end
            end
            if (cmd.kp_write)
            begin
                // saturate to all ones, covers a zero swing too
                if (|quotient[NUM_W-1:GAIN_W])
                    kp_reg <= '1;
                else
                    kp_reg <= quotient[GAIN_W-1:0];
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.process)
        begin
            drive_reg <= drive_next;
            diff_reg  <= diff_next;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(amp_clamp) * PROD_W'(KP_SCALE);
    end

    // round half up: add half the divisor
    assign numerator = NUM_W'(prod_reg) + NUM_W'(diff_reg >> 1);

    rzn_div #(
        .NUM_W (NUM_W),
        .DEN_W (TEMP_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .numerator (numerator),
        .divisor   (diff_reg),
        .done      (div_done),
        .quotient  (quotient)
    );

    // result register
    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit && out_free)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && out_free)
        begin
            out_drive_reg  <= drive_reg;
            out_status_reg <= phase_reg;
            out_kp_reg     <= kp_reg;
            out_ti_reg     <= ti_reg;
            out_td_reg     <= td_reg;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.heater_drive       = out_drive_reg;
    assign result.status             = out_status_reg;
    assign result.gain_kp            = out_kp_reg;
    assign result.integral_time_ms   = out_ti_reg;
    assign result.derivative_time_ms = out_td_reg;

    assign stat.item_valid = item.valid;
    assign stat.need_div   = finish && !low_swing;
    assign stat.div_done   = div_done;
    assign stat.out_free   = out_free;

endmodule

`default_nettype wire
